[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of the translator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with reset masking.
`define DPT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same-cycle implication between two expressions.
`define DPT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/core/dpt_pkg.sv]
// Types and constants of the demand paging translator.
`timescale 1ns / 1ps
package dpt_pkg;

    localparam int PAGE_AW      = 8;
    localparam int FRAME_AW     = 6;
    localparam int OFFSET_W     = 14;
    localparam int PHYS_W       = 20;
    localparam int BASE_SHIFT   = 10;
    localparam int MAX_SIZE_LOG = 4;

    localparam logic [2:0] OUT_HIT        = 3'd0;
    localparam logic [2:0] OUT_FAULT_FREE = 3'd1;
    localparam logic [2:0] OUT_FAULT_REPL = 3'd2;
    localparam logic [2:0] OUT_BAD_PAGE   = 3'd3;
    localparam logic [2:0] OUT_NO_FRAME   = 3'd4;
    localparam logic [2:0] OUT_RESTART    = 3'd5;

    localparam logic KIND_TRANSLATE = 1'b0;
    localparam logic KIND_RESTART   = 1'b1;

    localparam logic [1:0] REG_POLICY    = 2'd0;
    localparam logic [1:0] REG_SIZE_LOG  = 2'd1;
    localparam logic [1:0] REG_PAGES     = 2'd2;
    localparam logic [1:0] REG_FRAME_MAP = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [31:0] logical_addr;
    } in_beat_t;

    typedef struct packed {
        logic [19:0] phys_addr;
        logic [2:0]  outcome;
        logic [5:0]  frame_used;
        logic [3:0]  evicted_page;
        logic [31:0] access_total;
        logic [31:0] hit_total;
        logic [31:0] fault_total;
        logic [31:0] replace_total;
    } out_beat_t;

    typedef struct packed {
        logic        replace_policy;
        logic [2:0]  page_size_log;
        logic [4:0]  pages_in_use;
        logic [63:0] initial_frame_map;
    } cfg_t;

    typedef struct packed {
        logic                rd_en;
        logic [PAGE_AW-1:0]  rd_addr;
        logic                frame_we;
        logic [PAGE_AW-1:0]  frame_waddr;
        logic [FRAME_AW-1:0] frame_wdata;
        logic                prev_we;
        logic                next_we;
        logic [PAGE_AW-1:0]  link_waddr;
        logic [PAGE_AW-1:0]  link_wdata;
    } mem_req_t;

    typedef struct packed {
        logic [FRAME_AW-1:0] frame;
        logic [PAGE_AW-1:0]  prev;
        logic [PAGE_AW-1:0]  next;
    } mem_rsp_t;

endpackage

[rtl/core/dpt_cfg.sv]
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps
module dpt_cfg
    import dpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (paddr[4:3])
                REG_POLICY:    cfg_next.replace_policy    = pwdata[0];
                REG_SIZE_LOG:  cfg_next.page_size_log     = pwdata[2:0];
                REG_PAGES:     cfg_next.pages_in_use      = pwdata[4:0];
                REG_FRAME_MAP: cfg_next.initial_frame_map = pwdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.replace_policy    <= 1'b0;
            cfg_reg.page_size_log     <= 3'd0;
            cfg_reg.pages_in_use      <= 5'd16;
            cfg_reg.initial_frame_map <= 64'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            REG_POLICY:    prdata = 64'(cfg_reg.replace_policy);
            REG_SIZE_LOG:  prdata = 64'(cfg_reg.page_size_log);
            REG_PAGES:     prdata = 64'(cfg_reg.pages_in_use);
            REG_FRAME_MAP: prdata = cfg_reg.initial_frame_map;
            default:       prdata = 64'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/dpt_mem.sv]
// Page frame memory and residency link memory, with registered reads.
`timescale 1ns / 1ps
module dpt_mem
    import dpt_pkg::*;
#(
    parameter int PAGES  = 16,
    parameter int FRAMES = 64
)
(
    input  logic     clk,
    input  mem_req_t req,
    output mem_rsp_t rsp
);

    localparam int PW = $clog2(PAGES);
    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    logic [FW-1:0]   frame_mem [PAGES];
    logic [2*PW-1:0] link_mem  [PAGES];
    logic [FW-1:0]   frame_rd_reg;
    logic [2*PW-1:0] link_rd_reg;

    always_ff @(posedge clk)
    begin
        if (req.frame_we)
        begin
            frame_mem[req.frame_waddr[PW-1:0]] <= req.frame_wdata[FW-1:0];
        end
        if (req.rd_en)
        begin
            frame_rd_reg <= frame_mem[req.rd_addr[PW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.prev_we)
        begin
            link_mem[req.link_waddr[PW-1:0]][2*PW-1:PW] <= req.link_wdata[PW-1:0];
        end
        if (req.next_we)
        begin
            link_mem[req.link_waddr[PW-1:0]][PW-1:0] <= req.link_wdata[PW-1:0];
        end
        if (req.rd_en)
        begin
            link_rd_reg <= link_mem[req.rd_addr[PW-1:0]];
        end
    end

    assign rsp.frame = FRAME_AW'(frame_rd_reg);
    assign rsp.prev  = PAGE_AW'(link_rd_reg[2*PW-1:PW]);
    assign rsp.next  = PAGE_AW'(link_rd_reg[PW-1:0]);

endmodule

[rtl/core/dpt_ctrl.sv]
// Translation sequencer: page decode, hit and fault handling, restart, queue links, counters.
`timescale 1ns / 1ps
module dpt_ctrl
    import dpt_pkg::*;
#(
    parameter int PAGES  = 16,
    parameter int FRAMES = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data,
    output mem_req_t  mem_req,
    input  mem_rsp_t  mem_rsp
);

    localparam int PW = $clog2(PAGES);
    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DEC   = 3'd1;
    localparam logic [2:0] ST_HIT   = 3'd2;
    localparam logic [2:0] ST_EVICT = 3'd3;
    localparam logic [2:0] ST_RM    = 3'd4;
    localparam logic [2:0] ST_APA   = 3'd5;
    localparam logic [2:0] ST_APB   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [PW-1:0]       page_reg, page_next;
    logic                bad_reg, bad_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [3:0]          shift_reg, shift_next;
    logic [2:0]          outcome_reg, outcome_next;
    logic [FW-1:0]       frame_reg, frame_next;
    logic [PW-1:0]       evict_reg, evict_next;
    logic                grow_reg, grow_next;
    logic [PW-1:0]       prv_reg, prv_next;
    logic [PW-1:0]       nxt_reg, nxt_next;
    logic [PW-1:0]       head_reg, head_next;
    logic [PW-1:0]       tail_reg, tail_next;
    logic [PW:0]         count_reg, count_next;
    logic [PAGES-1:0]    valid_reg, valid_next;
    logic [FRAMES-1:0]   free_reg, free_next;
    logic [31:0]         acc_reg, acc_next;
    logic [31:0]         hit_reg, hit_next;
    logic [31:0]         fault_reg, fault_next;
    logic [31:0]         repl_reg, repl_next;
    out_beat_t           out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic [2:0]          size_log;
    logic [31:0]         page_full;
    logic [31:0]         limit;
    logic [FRAMES-1:0]   free_low;
    logic [FW-1:0]       low_idx;
    logic [PHYS_W-1:0]   phys;

    always_comb
    begin
        size_log  = (cfg.page_size_log > 3'(MAX_SIZE_LOG)) ? 3'(MAX_SIZE_LOG)
                                                           : cfg.page_size_log;
        page_full = in_data.logical_addr >> (BASE_SHIFT + int'(size_log));
        limit     = (32'(cfg.pages_in_use) > 32'(PAGES)) ? 32'(PAGES)
                                                         : 32'(cfg.pages_in_use);
        free_low  = free_reg & (~free_reg + 1'b1);
        low_idx   = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (free_low[i])
            begin
                low_idx = low_idx | FW'(i);
            end
        end
        phys = (PHYS_W'(frame_reg) << shift_reg) | PHYS_W'(offset_reg);
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        page_next      = page_reg;
        bad_next       = bad_reg;
        offset_next    = offset_reg;
        shift_next     = shift_reg;
        outcome_next   = outcome_reg;
        frame_next     = frame_reg;
        evict_next     = evict_reg;
        grow_next      = grow_reg;
        prv_next       = prv_reg;
        nxt_next       = nxt_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        valid_next     = valid_reg;
        free_next      = free_reg;
        acc_next       = acc_reg;
        hit_next       = hit_reg;
        fault_next     = fault_reg;
        repl_next      = repl_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        mem_req        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    frame_next = '0;
                    evict_next = '0;
                    if (in_data.kind == KIND_RESTART)
                    begin
                        valid_next   = '0;
                        free_next    = ~cfg.initial_frame_map[FRAMES-1:0];
                        count_next   = '0;
                        acc_next     = '0;
                        hit_next     = '0;
                        fault_next   = '0;
                        repl_next    = '0;
                        outcome_next = OUT_RESTART;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        page_next   = page_full[PW-1:0];
                        bad_next    = (page_full >= limit);
                        offset_next = in_data.logical_addr[OFFSET_W-1:0]
                                      & (14'h3fff >> (3'(MAX_SIZE_LOG) - size_log));
                        shift_next  = 4'(BASE_SHIFT) + 4'(size_log);
                        state_next  = ST_DEC;
                    end
                end
            end
            ST_DEC:
            begin
                acc_next = acc_reg + 32'd1;
                priority if (bad_reg)
                begin
                    outcome_next = OUT_BAD_PAGE;
                    state_next   = ST_OUT;
                end
                else if (valid_reg[page_reg])
                begin
                    hit_next        = hit_reg + 32'd1;
                    outcome_next    = OUT_HIT;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = PAGE_AW'(page_reg);
                    state_next      = ST_HIT;
                end
                else if (|free_reg)
                begin
                    fault_next            = fault_reg + 32'd1;
                    frame_next            = low_idx;
                    free_next             = free_reg & ~free_low;
                    valid_next[page_reg]  = 1'b1;
                    mem_req.frame_we      = 1'b1;
                    mem_req.frame_waddr   = PAGE_AW'(page_reg);
                    mem_req.frame_wdata   = FRAME_AW'(low_idx);
                    grow_next             = 1'b1;
                    outcome_next          = OUT_FAULT_FREE;
                    state_next            = ST_APA;
                end
                else if (count_reg != '0)
                begin
                    fault_next      = fault_reg + 32'd1;
                    repl_next       = repl_reg + 32'd1;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = PAGE_AW'(head_reg);
                    outcome_next    = OUT_FAULT_REPL;
                    state_next      = ST_EVICT;
                end
                else
                begin
                    fault_next   = fault_reg + 32'd1;
                    outcome_next = OUT_NO_FRAME;
                    state_next   = ST_OUT;
                end
            end
            ST_HIT:
            begin
                frame_next = mem_rsp.frame[FW-1:0];
                prv_next   = mem_rsp.prev[PW-1:0];
                nxt_next   = mem_rsp.next[PW-1:0];
                grow_next  = 1'b0;
                if (cfg.replace_policy && (page_reg != tail_reg))
                begin
                    if (page_reg == head_reg)
                    begin
                        head_next  = mem_rsp.next[PW-1:0];
                        state_next = ST_APA;
                    end
                    else
                    begin
                        mem_req.next_we    = 1'b1;
                        mem_req.link_waddr = mem_rsp.prev;
                        mem_req.link_wdata = mem_rsp.next;
                        state_next         = ST_RM;
                    end
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_RM:
            begin
                mem_req.prev_we    = 1'b1;
                mem_req.link_waddr = PAGE_AW'(nxt_reg);
                mem_req.link_wdata = PAGE_AW'(prv_reg);
                state_next         = ST_APA;
            end
            ST_EVICT:
            begin
                evict_next           = head_reg;
                frame_next           = mem_rsp.frame[FW-1:0];
                valid_next[head_reg] = 1'b0;
                valid_next[page_reg] = 1'b1;
                mem_req.frame_we     = 1'b1;
                mem_req.frame_waddr  = PAGE_AW'(page_reg);
                mem_req.frame_wdata  = mem_rsp.frame;
                grow_next            = 1'b0;
                if (count_reg == (PW+1)'(1))
                begin
                    head_next  = page_reg;
                    tail_next  = page_reg;
                    state_next = ST_OUT;
                end
                else
                begin
                    head_next  = mem_rsp.next[PW-1:0];
                    state_next = ST_APA;
                end
            end
            ST_APA:
            begin
                if (count_reg == '0)
                begin
                    head_next  = page_reg;
                    tail_next  = page_reg;
                    count_next = count_reg + 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    mem_req.next_we    = 1'b1;
                    mem_req.link_waddr = PAGE_AW'(tail_reg);
                    mem_req.link_wdata = PAGE_AW'(page_reg);
                    state_next         = ST_APB;
                end
            end
            ST_APB:
            begin
                mem_req.prev_we    = 1'b1;
                mem_req.link_waddr = PAGE_AW'(page_reg);
                mem_req.link_wdata = PAGE_AW'(tail_reg);
                tail_next          = page_reg;
                if (grow_reg)
                begin
                    count_next = count_reg + 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.phys_addr     = (outcome_reg <= OUT_FAULT_REPL) ? phys : '0;
                    out_next.outcome       = outcome_reg;
                    out_next.frame_used    = 6'(frame_reg);
                    out_next.evicted_page  = 4'(evict_reg);
                    out_next.access_total  = acc_reg;
                    out_next.hit_total     = hit_reg;
                    out_next.fault_total   = fault_reg;
                    out_next.replace_total = repl_reg;
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            valid_reg     <= '0;
            free_reg      <= {FRAMES{1'b1}};
            acc_reg       <= '0;
            hit_reg       <= '0;
            fault_reg     <= '0;
            repl_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            valid_reg     <= valid_next;
            free_reg      <= free_next;
            acc_reg       <= acc_next;
            hit_reg       <= hit_next;
            fault_reg     <= fault_next;
            repl_reg      <= repl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg    <= page_next;
        bad_reg     <= bad_next;
        offset_reg  <= offset_next;
        shift_reg   <= shift_next;
        outcome_reg <= outcome_next;
        frame_reg   <= frame_next;
        evict_reg   <= evict_next;
        grow_reg    <= grow_next;
        prv_reg     <= prv_next;
        nxt_reg     <= nxt_next;
        out_reg     <= out_next;
    end

endmodule

[rtl/core/demand_paging_translator_unit.sv]
// Top level of the demand paging address translator.
//
// The input channel takes one beat per request: a translate of a logical
// address or a restart. The output channel returns exactly one beat per
// request with the physical address, the outcome, the frame, the evicted page
// and the four running counters. Both channels use valid and ready.
// A restart goes straight to the output step; a bad page or a missing frame
// passes decode first; a hit also reads the page memory; a fault into a free
// frame appends the page; a replacement evicts the head first; an LRU hit that
// moves the page from the middle of the queue unlinks it. These steps are set
// by the single write port of the link memory, which holds the residency order
// as a doubly linked list. One request is in flight at a time. The next one is
// accepted in the cycle after the result enters the output register, even
// while that result waits. If the receiver stalls, the block holds its result
// and waits before loading the following one. Reset clears the valid bits, the
// frame map, the queue and the counters at once; no clearing pass is needed.
// Configuration is written through the APB-style port; the user must write it
// only while the block is idle, as the block itself does not enforce this.
`timescale 1ns / 1ps
module demand_paging_translator_unit
    import dpt_pkg::*;
#(
    parameter int PAGES  = 16,
    parameter int FRAMES = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      psel,
    input  logic      penable,
    input  logic      pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic      pready,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    cfg_t     cfg;
    mem_req_t mem_req;
    mem_rsp_t mem_rsp;

    assign pready = 1'b1;

    dpt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    dpt_mem #(
        .PAGES  (PAGES),
        .FRAMES (FRAMES)
    ) u_mem (
        .clk (clk),
        .req (mem_req),
        .rsp (mem_rsp)
    );

    dpt_ctrl #(
        .PAGES  (PAGES),
        .FRAMES (FRAMES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .mem_req   (mem_req),
        .mem_rsp   (mem_rsp)
    );

endmodule

[rtl/core/dpt_checker.sv]
// Port-level checker of the translator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dpt_checker
    import dpt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_beat_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_beat_t out_data
);

    `DPT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped")
    `DPT_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_data), "stalled beat changed")
    `DPT_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "accepted two requests back to back")
    `DPT_ASSERT_IMPLY(a_restart_zero, out_valid && out_data.outcome == OUT_RESTART, out_data.access_total == 32'd0 && out_data.hit_total == 32'd0 && out_data.fault_total == 32'd0 && out_data.replace_total == 32'd0 && out_data.phys_addr == 20'd0, "restart result not cleared")
    `DPT_ASSERT_IMPLY(a_bad_page_zero, out_valid && out_data.outcome == OUT_BAD_PAGE, out_data.phys_addr == 20'd0 && out_data.frame_used == 6'd0 && out_data.evicted_page == 4'd0, "bad page result carries data")

endmodule

bind demand_paging_translator_unit dpt_checker u_dpt_checker (.*);
